FILE: rtl/core/xtc_pkg.sv
// shared types and constants of the xor limit counting trie
package xtc_pkg;

    localparam int MAX_KEY_BITS = 10;
    localparam int COUNT_BITS   = 12;
    localparam int CFG_BITS     = 4;
    localparam int NODE_BITS    = MAX_KEY_BITS + 1;
    localparam int DEPTH_BITS   = $clog2(MAX_KEY_BITS + 1);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'(MAX_KEY_BITS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_COUNT  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode                 opcode;
        logic [MAX_KEY_BITS-1:0] key_value;
        logic [MAX_KEY_BITS-1:0] xor_limit;
    } t_in_req;

    typedef struct packed {
        logic [COUNT_BITS-1:0] match_count;
        t_status               status;
    } t_out_res;

    typedef enum logic [3:0] {
        WS_CLEAR,
        WS_IDLE,
        WS_DESCEND,
        WS_CHECK,
        WS_EVAL,
        WS_UPDATE,
        WS_UPD_TAIL,
        WS_QUERY,
        WS_Q_LAST,
        WS_Q_TAIL,
        WS_FINISH
    } t_walk_state;

endpackage

FILE: rtl/core/xtc_ram.sv
// single write port, single registered read port counter memory
module xtc_ram #(
    parameter int ADDR_BITS = 11,
    parameter int DATA_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [0:(1 << ADDR_BITS)-1];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/xtc_walker.sv
// bit serial trie walker: clearing pass, insert, remove and count sequencing
module xtc_walker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [xtc_pkg::CFG_BITS-1:0]        i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  xtc_pkg::t_in_req                    i_in_req,
    output logic                                o_res_valid,
    output xtc_pkg::t_out_res                   o_res,
    input  logic                                i_res_take,
    output logic                                o_ram_we,
    output logic [xtc_pkg::NODE_BITS-1:0]       o_ram_waddr,
    output logic [xtc_pkg::COUNT_BITS-1:0]      o_ram_wdata,
    output logic [xtc_pkg::NODE_BITS-1:0]       o_ram_raddr,
    input  logic [xtc_pkg::COUNT_BITS-1:0]      i_ram_rdata
);

    xtc_pkg::t_walk_state                  r_state, n_state;
    logic [xtc_pkg::DEPTH_BITS-1:0]        r_depth, n_depth;
    xtc_pkg::t_opcode                      r_op, n_op;
    logic [xtc_pkg::MAX_KEY_BITS-1:0]      r_key, n_key;
    logic [xtc_pkg::MAX_KEY_BITS-1:0]      r_key_hold, n_key_hold;
    logic [xtc_pkg::MAX_KEY_BITS-1:0]      r_lim, n_lim;
    logic [xtc_pkg::NODE_BITS-1:0]         r_node, n_node;
    logic [xtc_pkg::DEPTH_BITS-1:0]        r_lvl, n_lvl;
    logic [xtc_pkg::COUNT_BITS-1:0]        r_sum, n_sum;
    xtc_pkg::t_status                      r_status, n_status;
    logic                                  r_wr_pend, n_wr_pend;
    logic [xtc_pkg::NODE_BITS-1:0]         r_wr_addr, n_wr_addr;
    logic                                  r_acc_pend, n_acc_pend;
    logic [xtc_pkg::NODE_BITS-1:0]         r_clr_addr, n_clr_addr;

    logic                                  key_msb;
    logic                                  lim_msb;
    logic [xtc_pkg::NODE_BITS-1:0]         node_step;
    logic [xtc_pkg::DEPTH_BITS-1:0]        align_sh;
    logic [xtc_pkg::DEPTH_BITS-1:0]        cfg_depth;
    logic [xtc_pkg::NODE_BITS-1:0]         raddr;

    assign key_msb   = r_key[xtc_pkg::MAX_KEY_BITS-1];
    assign lim_msb   = r_lim[xtc_pkg::MAX_KEY_BITS-1];
    assign node_step = {r_node[xtc_pkg::NODE_BITS-2:0], key_msb};
    // top key bit in use lands on the msb of the shift registers
    assign align_sh  = xtc_pkg::DEPTH_MAX - r_depth;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_depth = xtc_pkg::DEPTH_BITS'(1);
        end else if (int'(i_cfg_wdata) > xtc_pkg::MAX_KEY_BITS) begin
            cfg_depth = xtc_pkg::DEPTH_MAX;
        end else begin
            cfg_depth = xtc_pkg::DEPTH_BITS'(i_cfg_wdata);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_depth    = r_depth;
        n_op       = r_op;
        n_key      = r_key;
        n_key_hold = r_key_hold;
        n_lim      = r_lim;
        n_node     = r_node;
        n_lvl      = r_lvl;
        n_sum      = r_sum;
        n_status   = r_status;
        n_wr_pend  = 1'b0;
        n_wr_addr  = r_wr_addr;
        n_acc_pend = 1'b0;
        n_clr_addr = r_clr_addr;
        raddr      = r_node;

        // read data from the previous cycle's count read
        if (r_acc_pend) begin
            n_sum = r_sum + i_ram_rdata;
        end

        unique case (r_state)
            xtc_pkg::WS_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = xtc_pkg::WS_IDLE;
                end
            end
            xtc_pkg::WS_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_in_req.opcode;
                    n_key      = i_in_req.key_value << align_sh;
                    n_key_hold = i_in_req.key_value << align_sh;
                    n_lim      = i_in_req.xor_limit << align_sh;
                    n_node     = xtc_pkg::NODE_BITS'(1);
                    n_lvl      = r_depth;
                    n_sum      = '0;
                    n_status   = xtc_pkg::ST_OK;
                    unique case (i_in_req.opcode)
                        xtc_pkg::OP_INSERT: n_state = xtc_pkg::WS_CHECK;
                        xtc_pkg::OP_REMOVE: n_state = xtc_pkg::WS_DESCEND;
                        xtc_pkg::OP_COUNT:  n_state = xtc_pkg::WS_QUERY;
                        default:            n_state = xtc_pkg::WS_FINISH;
                    endcase
                end
            end
            xtc_pkg::WS_DESCEND: begin
                // build the leaf index one key bit per cycle
                n_node = node_step;
                n_key  = r_key << 1;
                n_lvl  = r_lvl - 1'b1;
                if (r_lvl == xtc_pkg::DEPTH_BITS'(1)) begin
                    n_state = xtc_pkg::WS_CHECK;
                end
            end
            xtc_pkg::WS_CHECK: begin
                n_state = xtc_pkg::WS_EVAL;
            end
            xtc_pkg::WS_EVAL: begin
                if (r_op == xtc_pkg::OP_INSERT && i_ram_rdata == xtc_pkg::COUNT_MAX) begin
                    n_status = xtc_pkg::ST_OVERFLOW;
                    n_state  = xtc_pkg::WS_FINISH;
                end else if (r_op == xtc_pkg::OP_REMOVE && i_ram_rdata == '0) begin
                    n_status = xtc_pkg::ST_ABSENT;
                    n_state  = xtc_pkg::WS_FINISH;
                end else begin
                    n_node  = xtc_pkg::NODE_BITS'(1);
                    n_key   = r_key_hold;
                    n_lvl   = r_depth;
                    n_state = xtc_pkg::WS_UPDATE;
                end
            end
            xtc_pkg::WS_UPDATE: begin
                // read here, write back in the following cycle while the next level reads
                n_wr_pend = 1'b1;
                n_wr_addr = r_node;
                n_node    = node_step;
                n_key     = r_key << 1;
                if (r_lvl == '0) begin
                    n_state = xtc_pkg::WS_UPD_TAIL;
                end else begin
                    n_lvl = r_lvl - 1'b1;
                end
            end
            xtc_pkg::WS_UPD_TAIL: begin
                n_state = xtc_pkg::WS_FINISH;
            end
            xtc_pkg::WS_QUERY: begin
                // limit bit set: take the whole subtree on the equal side, go the other way
                raddr      = node_step;
                n_acc_pend = lim_msb;
                n_node     = {r_node[xtc_pkg::NODE_BITS-2:0], key_msb ^ lim_msb};
                n_key      = r_key << 1;
                n_lim      = r_lim << 1;
                n_lvl      = r_lvl - 1'b1;
                if (r_lvl == xtc_pkg::DEPTH_BITS'(1)) begin
                    n_state = xtc_pkg::WS_Q_LAST;
                end
            end
            xtc_pkg::WS_Q_LAST: begin
                n_acc_pend = 1'b1;
                n_state    = xtc_pkg::WS_Q_TAIL;
            end
            xtc_pkg::WS_Q_TAIL: begin
                n_state = xtc_pkg::WS_FINISH;
            end
            xtc_pkg::WS_FINISH: begin
                if (i_res_take) begin
                    n_state = xtc_pkg::WS_IDLE;
                end
            end
            default: begin
                n_state = xtc_pkg::WS_CLEAR;
            end
        endcase

        // new depth changes the trie layout, so every counter goes back to zero
        if (i_cfg_we) begin
            n_depth    = cfg_depth;
            n_state    = xtc_pkg::WS_CLEAR;
            n_clr_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= xtc_pkg::WS_CLEAR;
            r_depth    <= xtc_pkg::DEPTH_MAX;
            r_clr_addr <= '0;
            r_wr_pend  <= 1'b0;
            r_acc_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_depth    <= n_depth;
            r_clr_addr <= n_clr_addr;
            r_wr_pend  <= n_wr_pend;
            r_acc_pend <= n_acc_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_key_hold <= n_key_hold;
        r_lim      <= n_lim;
        r_node     <= n_node;
        r_lvl      <= n_lvl;
        r_sum      <= n_sum;
        r_status   <= n_status;
        r_wr_addr  <= n_wr_addr;
    end

    assign o_in_stall  = (r_state != xtc_pkg::WS_IDLE);
    assign o_res_valid = (r_state == xtc_pkg::WS_FINISH);
    assign o_res       = '{match_count: r_sum, status: r_status};

    assign o_ram_raddr = raddr;
    assign o_ram_we    = (r_state == xtc_pkg::WS_CLEAR) || r_wr_pend;
    assign o_ram_waddr = (r_state == xtc_pkg::WS_CLEAR) ? r_clr_addr : r_wr_addr;
    assign o_ram_wdata = (r_state == xtc_pkg::WS_CLEAR) ? '0 :
                         (r_op == xtc_pkg::OP_INSERT) ? i_ram_rdata + 1'b1 :
                                                       i_ram_rdata - 1'b1;

`ifndef NO_ASSERTIONS
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_pend && r_state == xtc_pkg::WS_UPDATE) |-> (raddr != r_wr_addr))
        else $error("walker reads the counter it is writing back");

    a_insert_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_pend && r_op == xtc_pkg::OP_INSERT) |-> (i_ram_rdata != xtc_pkg::COUNT_MAX))
        else $error("insert wraps a counter on its path");

    a_remove_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_pend && r_op == xtc_pkg::OP_REMOVE) |-> (i_ram_rdata != '0))
        else $error("remove takes a counter on its path below zero");

    a_result_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (!r_wr_pend && !r_acc_pend))
        else $error("result offered with a memory access still in flight");
`endif

endmodule

FILE: rtl/core/xor_trie_count_below_limit_unit.sv
// top level of the xor limit counting trie: walker, counter memory and result register
//
// Keeps a multiset of keys as prefix counters of a binary trie key_bits levels deep and
// answers insert, remove and "how many stored x have (x xor y) <= k" requests, one result
// per request. The walker handles one request at a time, one trie level per cycle, because
// each level needs one access to the single-read-port counter memory. A remove first
// locates the leaf, then updates the path; an insert updates the path directly and a count
// walks it once. A rejected insert or remove returns its status without touching the
// counters. After reset and after every write of key_bits, a clearing pass zeroes the
// counters, one per cycle, and requests are stalled until it ends. The result register
// lets the next request be accepted while an earlier result is still stalled.
module xor_trie_count_below_limit_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [xtc_pkg::CFG_BITS-1:0]    i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  xtc_pkg::t_in_req                i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output xtc_pkg::t_out_res               o_out_res
);

    logic                               res_valid;
    logic                               res_take;
    xtc_pkg::t_out_res                  res;
    logic                               ram_we;
    logic [xtc_pkg::NODE_BITS-1:0]      ram_waddr;
    logic [xtc_pkg::COUNT_BITS-1:0]     ram_wdata;
    logic [xtc_pkg::NODE_BITS-1:0]      ram_raddr;
    logic [xtc_pkg::COUNT_BITS-1:0]     ram_rdata;

    logic                               r_out_valid;
    xtc_pkg::t_out_res                  r_out_res;

    xtc_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    xtc_ram #(
        .ADDR_BITS (xtc_pkg::NODE_BITS),
        .DATA_BITS (xtc_pkg::COUNT_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result register frees up when empty or when its result leaves this cycle
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule
